// ===== hdl/dmpc_pkg.sv =====
// shared types and constants of the debounced multi-channel pulse counter
package dmpc_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned DefChannels = 6;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned PinW        = 8;
  localparam int unsigned TickW       = 16;
  localparam int unsigned CountW      = 27;
  localparam int unsigned HalfW       = 16;
  localparam int unsigned OperandW    = 2 * HalfW;

  localparam logic [TickW-1:0]    DefDebounce = TickW'(20);
  localparam logic [OperandW-1:0] CountLimit  = OperandW'(100000000);
  localparam logic [HalfW-1:0]    HalfBlank   = '1;

  typedef enum logic [1:0] {
    KindTick = 2'd0,
    KindEdge = 2'd1,
    KindSet  = 2'd2,
    KindLoad = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CauseCount = 2'd0,
    CauseSet   = 2'd1,
    CauseLoad  = 2'd2
  } cause_e;

endpackage

// ===== hdl/dmpc_unit.sv =====
// shared counter arithmetic: increment with wrap, set clamp, load rebuild and clamp
module dmpc_unit import dmpc_pkg::*; (
  input  kind_e              kind_i,
  input  logic [CountW-1:0]  cur_i,
  input  logic [CountW-1:0]  set_value_i,
  input  logic [HalfW-1:0]   load_high_i,
  input  logic [HalfW-1:0]   load_low_i,
  output logic [CountW-1:0]  res_o
);

  logic [OperandW-1:0] operand;
  logic [HalfW-1:0]    high_part;
  logic                over;

  always_comb begin
    high_part = (load_high_i == HalfBlank) ? '0 : load_high_i;
    case (kind_i)
      KindTick: operand = OperandW'(cur_i) + OperandW'(1);
      KindSet:  operand = OperandW'(set_value_i);
      KindLoad: operand = {high_part, load_low_i};
      default:  operand = OperandW'(cur_i);
    endcase
    over = operand > CountLimit;
    if (over) begin
      res_o = (kind_i == KindTick) ? '0 : CountW'(CountLimit);
    end else begin
      res_o = operand[CountW-1:0];
    end
  end

endmodule

// ===== hdl/debounced_multi_channel_pulse_counter.sv =====
// top level: per-channel debounce windows and counters scanned by one shared unit
//
//  channel | handshake                     | carries
//  in      | in_valid_i / in_stall_o       | kind, channel, pin levels, set value, load halves
//  out     | out_valid_o / out_stall_i     | channel, count and halves, high change, cause, last
//  cfg     | cfg_valid_i / cfg_ready_o     | debounce_ticks
//
//  an edge arms an unarmed window from idle; a set or load goes through StCalc and StEmit
//  a tick walks the channels one a cycle in StScan, leaving for StEmit at each
//  counted channel, where the shared unit's result is registered
//  reset clears all windows, counters and stored high halves; debounce_ticks is 20
//  a stalled output holds the scan until the output register is free
module debounced_multi_channel_pulse_counter import dmpc_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [TickW-1:0]   cfg_debounce_ticks_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [ChanW-1:0]   channel_i,
  input  logic [PinW-1:0]    pin_levels_i,
  input  logic [CountW-1:0]  set_value_i,
  input  logic [HalfW-1:0]   load_high_i,
  input  logic [HalfW-1:0]   load_low_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ChanW-1:0]   out_channel_o,
  output logic [CountW-1:0]  count_o,
  output logic [HalfW-1:0]   count_high_o,
  output logic [HalfW-1:0]   count_low_o,
  output logic               high_changed_o,
  output logic [1:0]         cause_o,
  output logic               last_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StCalc,
    StEmit
  } state_e;

  state_e              state_q;
  kind_e               kind_q;
  logic [IdxW-1:0]     idx_q;
  logic [CHANNELS-1:0] hit_q;
  logic [TickW-1:0]    debounce_q;
  logic [CountW-1:0]   set_q;
  logic [HalfW-1:0]    load_high_q;
  logic [HalfW-1:0]    load_low_q;
  logic [CountW-1:0]   res_q;

  logic                armed_q [CHANNELS];
  logic [TickW-1:0]    rem_q   [CHANNELS];
  logic [CountW-1:0]   cnt_q   [CHANNELS];
  logic [HalfW-1:0]    shigh_q [CHANNELS];

  logic                out_valid_q;
  logic [ChanW-1:0]    out_channel_q;
  logic [CountW-1:0]   count_q;
  logic                changed_q;
  cause_e              cause_q;
  logic                last_q;

  logic [CHANNELS-1:0] hit_d;
  logic [HalfW-1:0]    shigh_d [CHANNELS];
  logic                more_hits;
  logic                ch_ok;
  logic [IdxW-1:0]     ch_idx;
  logic [HalfW-1:0]    res_high;
  logic                changed;
  logic                out_free;
  logic                emit_last;
  logic [CountW-1:0]   unit_res;
  cause_e              cause_d;

  dmpc_unit u_unit (
    .kind_i      (kind_q),
    .cur_i       (cnt_q[idx_q]),
    .set_value_i (set_q),
    .load_high_i (load_high_q),
    .load_low_i  (load_low_q),
    .res_o       (unit_res)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign ch_ok       = {1'b0, channel_i} < (ChanW + 1)'(CHANNELS);
  assign ch_idx      = channel_i[IdxW-1:0];
  assign res_high    = HalfW'(res_q >> HalfW);
  assign changed     = res_high != shigh_q[idx_q];
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_last   = (kind_q != KindTick) || !more_hits;

  always_comb begin
    more_hits = 1'b0;
    for (int j = 0; j < CHANNELS; j++) begin
      hit_d[j] = armed_q[j] && (rem_q[j] <= TickW'(1)) && !pin_levels_i[j];
      if (j > int'(idx_q) && hit_q[j]) begin
        more_hits = 1'b1;
      end
      if (j == int'(idx_q)) begin
        shigh_d[j] = res_high;
      end else begin
        shigh_d[j] = HalfW'(cnt_q[j] >> HalfW);
      end
    end
    case (kind_q)
      KindSet:  cause_d = CauseSet;
      KindLoad: cause_d = CauseLoad;
      default:  cause_d = CauseCount;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      kind_q        <= KindTick;
      idx_q         <= '0;
      hit_q         <= '0;
      debounce_q    <= DefDebounce;
      set_q         <= '0;
      load_high_q   <= '0;
      load_low_q    <= '0;
      res_q         <= '0;
      out_valid_q   <= 1'b0;
      out_channel_q <= '0;
      count_q       <= '0;
      changed_q     <= 1'b0;
      cause_q       <= CauseCount;
      last_q        <= 1'b0;
      for (int j = 0; j < CHANNELS; j++) begin
        armed_q[j] <= 1'b0;
        rem_q[j]   <= '0;
        cnt_q[j]   <= '0;
        shigh_q[j] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        debounce_q <= cfg_debounce_ticks_i;
      end
      if (state_q == StEmit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            kind_q      <= kind_e'(kind_i);
            set_q       <= set_value_i;
            load_high_q <= load_high_i;
            load_low_q  <= load_low_i;
            case (kind_e'(kind_i))
              KindTick: begin
                hit_q   <= hit_d;
                idx_q   <= '0;
                state_q <= StScan;
              end
              KindEdge: begin
                if (ch_ok && !armed_q[ch_idx]) begin
                  armed_q[ch_idx] <= 1'b1;
                  rem_q[ch_idx]   <= debounce_q;
                end
              end
              KindSet: begin
                if (ch_ok) begin
                  idx_q   <= ch_idx;
                  state_q <= StCalc;
                end
              end
              KindLoad: begin
                if (ch_ok) begin
                  armed_q[ch_idx] <= 1'b0;
                  rem_q[ch_idx]   <= '0;
                  shigh_q[ch_idx] <= load_high_i;
                  idx_q           <= ch_idx;
                  state_q         <= StCalc;
                end
              end
              default: ;
            endcase
          end
        end
        StScan: begin
          if (armed_q[idx_q]) begin
            if (rem_q[idx_q] > TickW'(1)) begin
              rem_q[idx_q] <= rem_q[idx_q] - TickW'(1);
            end else begin
              armed_q[idx_q] <= 1'b0;
              rem_q[idx_q]   <= '0;
            end
          end
          if (hit_q[idx_q]) begin
            res_q   <= unit_res;
            state_q <= StEmit;
          end else if (idx_q == LastIdx) begin
            state_q <= StIdle;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        StCalc: begin
          res_q   <= unit_res;
          state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            cnt_q[idx_q] <= res_q;
            if (changed) begin
              for (int j = 0; j < CHANNELS; j++) begin
                shigh_q[j] <= shigh_d[j];
              end
            end
            out_channel_q <= ChanW'(idx_q);
            count_q       <= res_q;
            changed_q     <= changed;
            cause_q       <= cause_d;
            last_q        <= emit_last;
            if (kind_q != KindTick || idx_q == LastIdx) begin
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              state_q <= StScan;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = out_channel_q;
  assign count_o        = count_q;
  assign count_high_o   = HalfW'(count_q >> HalfW);
  assign count_low_o    = count_q[HalfW-1:0];
  assign high_changed_o = changed_q;
  assign cause_o        = cause_q;
  assign last_o         = last_q;

endmodule
